// ----- sv/csvt_pkg.sv -----
// CSV tokenizer package: character codes, parser state encoding and the
// structs shared by the parser state machine and the top level.
// No dependencies.
package csvt_pkg;

  // Character codes the parser reacts to
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Parser states; the two unused codes behave as ST_DATA
  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_DATA_CR  = 3'd1,
    ST_FIELD    = 3'd2,
    ST_QUOTED   = 3'd3,
    ST_QUOTE_IN = 3'd4,
    ST_QUOTE_CR = 3'd5
  } state_t;

  // One result item as produced by the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
  } result_t;

endpackage

// ----- sv/csvt_fsm.sv -----
// CSV parser state machine: parser state registers and the combinational
// next-state and result logic for one byte or end-of-input item.
// Depends on csvt_pkg.
module csvt_fsm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [7:0]         in_byte,
  input  logic               in_eoi,
  output csvt_pkg::result_t  res
);

  csvt_pkg::state_t state_r, state_nxt;
  logic fhb_r, fhb_nxt;
  logic rhf_r, rhf_nxt;
  logic lwc_r, lwc_nxt;

  // Hold parser state; advance only when the held item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csvt_pkg::ST_DATA;
      fhb_r   <= 1'b0;
      rhf_r   <= 1'b0;
      lwc_r   <= 1'b0;
    end else if (adv) begin
      state_r <= state_nxt;
      fhb_r   <= fhb_nxt;
      rhf_r   <= rhf_nxt;
      lwc_r   <= lwc_nxt;
    end
  end

  // Next state and result; reconsumed bytes resolve through eff_state
  always_comb begin
    csvt_pkg::state_t eff_state;
    logic is_comma, is_cr, is_lf, is_quote, is_delim, done;
    logic in_data, fe, rec;

    is_comma  = (in_byte == csvt_pkg::CH_COMMA);
    is_cr     = (in_byte == csvt_pkg::CH_CR);
    is_lf     = (in_byte == csvt_pkg::CH_LF);
    is_quote  = (in_byte == csvt_pkg::CH_QUOTE);
    is_delim  = is_comma || is_cr || is_lf;
    state_nxt = state_r;
    fhb_nxt   = fhb_r;
    rhf_nxt   = rhf_r;
    lwc_nxt   = lwc_r;
    res       = '0;
    eff_state = state_r;
    done      = 1'b0;
    in_data   = (state_r == csvt_pkg::ST_DATA) || (state_r > csvt_pkg::ST_QUOTE_CR);
    fe        = fhb_r || (in_data && lwc_r) || (state_r == csvt_pkg::ST_FIELD) ||
                (state_r == csvt_pkg::ST_QUOTED) || (state_r == csvt_pkg::ST_QUOTE_IN);
    rec       = rhf_r || fe;

    if (in_eoi) begin
      // Flush the open field and record, then drop back to reset state
      state_nxt      = csvt_pkg::ST_DATA;
      fhb_nxt        = 1'b0;
      rhf_nxt        = 1'b0;
      lwc_nxt        = 1'b0;
      res.valid      = rec;
      res.field_end  = fe;
      res.record_end = rec;
    end else begin
      lwc_nxt = is_comma;

      // First pass: states that pass the byte on to another state
      unique case (state_r)
        csvt_pkg::ST_DATA_CR: begin
          if (is_lf) begin
            state_nxt = csvt_pkg::ST_DATA;
            done      = 1'b1;
          end else begin
            eff_state = csvt_pkg::ST_DATA;
          end
        end
        csvt_pkg::ST_QUOTE_CR: begin
          if (is_lf) begin
            state_nxt = csvt_pkg::ST_QUOTED;
            done      = 1'b1;
          end else begin
            eff_state = csvt_pkg::ST_QUOTED;
          end
        end
        csvt_pkg::ST_FIELD, csvt_pkg::ST_QUOTE_IN: begin
          if (is_delim) begin
            eff_state = csvt_pkg::ST_DATA;
          end
        end
        csvt_pkg::ST_DATA, csvt_pkg::ST_QUOTED: begin
          eff_state = state_r;
        end
        default: begin
          eff_state = csvt_pkg::ST_DATA;
        end
      endcase

      // Second pass: consume the byte
      if (!done) begin
        unique case (eff_state)
          csvt_pkg::ST_FIELD: begin
            state_nxt      = csvt_pkg::ST_FIELD;
            fhb_nxt        = 1'b1;
            res.valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.data       = in_byte;
          end
          csvt_pkg::ST_QUOTED: begin
            if (is_quote) begin
              state_nxt = csvt_pkg::ST_QUOTE_IN;
            end else begin
              state_nxt      = is_cr ? csvt_pkg::ST_QUOTE_CR : csvt_pkg::ST_QUOTED;
              fhb_nxt        = 1'b1;
              res.valid      = 1'b1;
              res.byte_valid = 1'b1;
              res.data       = is_cr ? csvt_pkg::CH_LF : in_byte;
            end
          end
          csvt_pkg::ST_QUOTE_IN: begin
            // Doubled quote stays quoted; stray text continues unquoted
            state_nxt      = is_quote ? csvt_pkg::ST_QUOTED : csvt_pkg::ST_FIELD;
            fhb_nxt        = 1'b1;
            res.valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.data       = in_byte;
          end
          default: begin
            if (is_delim) begin
              state_nxt      = is_cr ? csvt_pkg::ST_DATA_CR : csvt_pkg::ST_DATA;
              fhb_nxt        = 1'b0;
              rhf_nxt        = is_comma;
              res.valid      = 1'b1;
              res.field_end  = 1'b1;
              res.record_end = !is_comma;
            end else if (is_quote) begin
              state_nxt = csvt_pkg::ST_QUOTED;
            end else begin
              state_nxt      = csvt_pkg::ST_FIELD;
              fhb_nxt        = 1'b1;
              res.valid      = 1'b1;
              res.byte_valid = 1'b1;
              res.data       = in_byte;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- sv/csv_byte_tokenizer_top.sv -----
// CSV byte tokenizer top level: input register, parser state machine and
// result register with valid/ready on both sides.
// Depends on csvt_pkg and csvt_fsm.
//
// Usage:
//   The input channel takes one item per accepted cycle: a raw CSV byte in
//   in_byte, or an end-of-stream mark in in_end_of_input (in_byte ignored).
//   Each item yields zero or one result item: a content byte
//   (out_byte_valid), or a field end (out_field_end) that may carry a record
//   end (out_record_end); an end-of-stream item may yield a field and record end.
//   out_byte reads 0 when no content byte is carried.
//   An accepted item is held in the input register and its result in the
//   result register. One item is accepted every cycle unless a result item
//   stalls; the single parser state update per item sets this rate, and
//   opening quotes, the LF of a CRLF and similar bytes yield no result and
//   simply vanish. When the receiver stalls, the result register holds its
//   item and the input register still moves on while its item yields
//   nothing; otherwise in_ready drops until out_ready returns.
//   Reset (rst_n low, synchronous) empties both registers and puts the
//   parser in its data state with all flags clear. After end of stream the
//   parser returns to the same state.
module csv_byte_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_field_end,
  output logic       out_record_end
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_eoi_r;
  logic              s1_adv;
  logic              out_free;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_bv_r;
  logic              out_fe_r;
  logic              out_re_r;
  csvt_pkg::result_t res;

  // Move the held item on when its result has somewhere to go
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!res.valid || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_eoi_r  <= in_end_of_input;
    end
  end

  csvt_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .in_byte (s1_byte_r),
    .in_eoi  (s1_eoi_r),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && res.valid) begin
      out_byte_r <= res.data;
      out_bv_r   <= res.byte_valid;
      out_fe_r   <= res.field_end;
      out_re_r   <= res.record_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_field_end  = out_fe_r;
  assign out_record_end = out_re_r;

endmodule

// ----- sv/csvt_checker.sv -----
// Port-level checks for the CSV byte tokenizer, bound to the top level.
// Depends only on the ports of csv_byte_tokenizer_top.
module csvt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_end_of_input,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_field_end,
  input logic       out_record_end
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(out_byte_valid) && $stable(out_field_end) && $stable(out_record_end))
    else $error("result item changed while stalled");

  // A result carries a content byte or an end mark, never both
  a_byte_or_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_byte_valid && (out_field_end || out_record_end)))
    else $error("content byte and end mark in one item");

  // A result is never empty
  a_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_valid || out_field_end || out_record_end))
    else $error("empty result item");

  // Byte lane reads zero when no content byte is carried
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'h00)
    else $error("nonzero byte lane without content byte");

endmodule

bind csv_byte_tokenizer_top csvt_checker u_csvt_checker (.*);

// ----- tb/csv_byte_tokenizer_checker.sv -----
// Checker for the CSV byte tokenizer: watches both item channels, predicts
// the token for every accepted input byte and compares each result field.
// Depends on csvt_pkg for the character codes and the parser state encoding.
module csv_byte_tokenizer_checker
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_byte_valid,
  input  logic       out_field_end,
  input  logic       out_record_end,
  output int         fail_cnt,
  output int         pending,
  output int         n_checked,
  output int         n_records
);

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
  } token_t;

  // Tokenizer state as the predictor sees it
  state_t st;
  logic   has_bytes;
  logic   rec_has_fields;
  logic   after_comma;

  token_t token_q[$];
  int     n_fail;
  int     n_tok;
  int     n_rec;

  initial begin
    fail_cnt  = 0;
    pending   = 0;
    n_checked = 0;
    n_records = 0;
    n_fail    = 0;
    n_tok     = 0;
    n_rec     = 0;
  end

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_CR) || (c == CH_LF);
  endfunction

  task automatic clear_parser();
    st             = ST_DATA;
    has_bytes      = 1'b0;
    rec_has_fields = 1'b0;
    after_comma    = 1'b0;
  endtask

  // Advance the predicted parser by one item; bytes that leave a state
  // unused are handled again in the next state within the same item.
  task automatic tokenize(input logic [7:0] c, input logic eoi,
                          output logic got, output token_t tok);
    logic again;
    logic in_data;
    logic fe;
    logic rec;
    int   step_i;
    got = 1'b0;
    tok = '0;
    if (eoi) begin
      in_data = !(st == ST_DATA_CR || st == ST_FIELD || st == ST_QUOTED ||
                  st == ST_QUOTE_IN || st == ST_QUOTE_CR);
      fe  = has_bytes || (in_data && after_comma) ||
            st == ST_FIELD || st == ST_QUOTED || st == ST_QUOTE_IN;
      rec = rec_has_fields || fe;
      clear_parser();
      if (fe || rec) begin
        got            = 1'b1;
        tok.field_end  = fe;
        tok.record_end = rec;
      end
    end else begin
      after_comma = (c == CH_COMMA);
      again       = 1'b1;
      for (step_i = 0; step_i < 4 && again; step_i++) begin
        again = 1'b0;
        case (st)
          ST_DATA_CR: begin
            st    = ST_DATA;
            again = (c != CH_LF);
          end
          ST_FIELD: begin
            if (is_delim(c)) begin
              st    = ST_DATA;
              again = 1'b1;
            end else begin
              has_bytes      = 1'b1;
              got            = 1'b1;
              tok.data       = c;
              tok.byte_valid = 1'b1;
            end
          end
          ST_QUOTED: begin
            if (c == CH_QUOTE) begin
              st = ST_QUOTE_IN;
            end else begin
              // CR inside quotes turns into one LF content byte
              if (c == CH_CR) st = ST_QUOTE_CR;
              has_bytes      = 1'b1;
              got            = 1'b1;
              tok.data       = (c == CH_CR) ? CH_LF : c;
              tok.byte_valid = 1'b1;
            end
          end
          ST_QUOTE_IN: begin
            if (is_delim(c)) begin
              st    = ST_DATA;
              again = 1'b1;
            end else begin
              // doubled quote stays quoted, stray text goes unquoted
              st             = (c == CH_QUOTE) ? ST_QUOTED : ST_FIELD;
              has_bytes      = 1'b1;
              got            = 1'b1;
              tok.data       = c;
              tok.byte_valid = 1'b1;
            end
          end
          ST_QUOTE_CR: begin
            st    = ST_QUOTED;
            again = (c != CH_LF);
          end
          default: begin
            if (is_delim(c)) begin
              st             = (c == CH_CR) ? ST_DATA_CR : ST_DATA;
              has_bytes      = 1'b0;
              rec_has_fields = (c == CH_COMMA);
              got            = 1'b1;
              tok.field_end  = 1'b1;
              tok.record_end = (c != CH_COMMA);
            end else if (c == CH_QUOTE) begin
              st = ST_QUOTED;
            end else begin
              st    = ST_FIELD;
              again = 1'b1;
            end
          end
        endcase
      end
    end
  endtask

  // Compare results first: a result never belongs to an input taken at the
  // same edge, then predict from the accepted input item.
  always @(posedge clk) begin
    logic   got;
    token_t tok;
    token_t want;
    if (!rst_n) begin
      clear_parser();
      token_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        n_tok++;
        if (out_record_end) n_rec++;
        if (token_q.size() == 0) begin
          $error("unexpected result item: byte %0h bv %0b fe %0b re %0b",
                 out_byte, out_byte_valid, out_field_end, out_record_end);
          n_fail++;
        end else begin
          want = token_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, actual %0h", want.data, out_byte);
            n_fail++;
          end
          if (out_byte_valid !== want.byte_valid) begin
            $error("out_byte_valid: expected %0b, actual %0b",
                   want.byte_valid, out_byte_valid);
            n_fail++;
          end
          if (out_field_end !== want.field_end) begin
            $error("out_field_end: expected %0b, actual %0b",
                   want.field_end, out_field_end);
            n_fail++;
          end
          if (out_record_end !== want.record_end) begin
            $error("out_record_end: expected %0b, actual %0b",
                   want.record_end, out_record_end);
            n_fail++;
          end
        end
      end
      if (in_valid && in_ready) begin
        tokenize(in_byte, in_end_of_input, got, tok);
        if (got) token_q.insert(token_q.size(), tok);
      end
    end
    fail_cnt  <= n_fail;
    pending   <= token_q.size();
    n_checked <= n_tok;
    n_records <= n_rec;
  end

endmodule

// ----- tb/csv_byte_tokenizer_top_tb.sv -----
// Testbench top for csv_byte_tokenizer_top: drives directed and random CSV
// byte streams, toggles ready on the result side and reports the verdict.
// Depends on csvt_pkg, csv_byte_tokenizer_top and csv_byte_tokenizer_checker.
module csv_byte_tokenizer_top_tb;
  import csvt_pkg::*;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte         = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready       = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_field_end;
  logic       out_record_end;

  int chk_fail;
  int chk_pending;
  int chk_checked;
  int chk_records;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int n_sent        = 0;
  int n_eoi         = 0;

  logic stall_req  = 1'b0;
  logic stall_done = 1'b0;
  int   stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  csv_byte_tokenizer_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_field_end   (out_field_end),
    .out_record_end  (out_record_end)
  );

  csv_byte_tokenizer_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .out_field_end   (out_field_end),
    .out_record_end  (out_record_end),
    .fail_cnt        (chk_fail),
    .pending         (chk_pending),
    .n_checked       (chk_checked),
    .n_records       (chk_records)
  );

  // Drive result-side ready; hold it low for one long stretch on request
  always @(posedge clk) begin
    if (stall_req && !stall_done) begin
      stall_done <= 1'b1;
      stall_left <= 300;
      out_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    if (eoi) n_eoi++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == CH_COMMA || b == CH_CR || b == CH_LF || b == CH_QUOTE);
    return b;
  endfunction

  task automatic send_plain(input int len);
    for (int i = 0; i < len; i++) send_item(plain_byte(), 1'b0);
  endtask

  // Quoted field with random content: doubled quotes, CR, CRLF, commas, LF
  task automatic send_quoted(input int len, input logic stray);
    int         r;
    logic [7:0] b;
    send_item(CH_QUOTE, 1'b0);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_item(CH_QUOTE, 1'b0);
        send_item(CH_QUOTE, 1'b0);
      end else if (r < 22) begin
        send_item(CH_CR, 1'b0);
        if ($urandom_range(1)) send_item(CH_LF, 1'b0);
      end else begin
        do b = 8'($urandom_range(255));
        while (b == CH_QUOTE);
        send_item(b, 1'b0);
      end
    end
    send_item(CH_QUOTE, 1'b0);
    if (stray) send_plain($urandom_range(1, 3));
  endtask

  // One record with random fields (some with stray text after a closing quote) and a random line ending
  task automatic send_record();
    int nf;
    int r;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send_item(CH_COMMA, 1'b0);
      r = $urandom_range(99);
      if (r < 40)      send_plain($urandom_range(1, 5));
      else if (r < 80) send_quoted($urandom_range(0, 5), 1'b0);
      else if (r < 90) send_quoted($urandom_range(0, 3), 1'b1);
    end
    r = $urandom_range(99);
    if (r < 40) begin
      send_item(CH_LF, 1'b0);
    end else if (r < 70) begin
      send_item(CH_CR, 1'b0);
      send_item(CH_LF, 1'b0);
    end else if (r < 90) begin
      send_item(CH_CR, 1'b0);
    end else begin
      send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  // Mostly records, some raw noise and stray end-of-stream marks
  task automatic run_random(input int n_items);
    int stop_at;
    int r;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 78) begin
        send_record();
      end else if (r < 92) begin
        for (int i = $urandom_range(1, 8); i > 0; i--) begin
          if ($urandom_range(3) == 0)
            send_item(CH_QUOTE, 1'b0);
          else
            send_item(8'($urandom_range(255)), 1'b0);
        end
      end else begin
        send_item(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, separators, quoting corner cases, stream ends
    send_item(8'h00, 1'b1);      // end of stream on an empty parser
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CH_COMMA, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_CR, 1'b0);      // CRLF inside quotes folds to one LF
    send_item(CH_LF, 1'b0);
    send_item(CH_CR, 1'b0);      // lone CR inside quotes, then text
    send_item(8'h61, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_QUOTE, 1'b0);   // doubled quote
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h7A, 1'b0);      // text after the closing quote
    send_item(CH_CR, 1'b0);
    send_item(8'h62, 1'b0);      // byte after CR without LF
    send_item(CH_LF, 1'b0);
    send_item(CH_COMMA, 1'b0);
    send_item(8'hFF, 1'b1);      // end right after a comma
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h00, 1'b1);      // end inside an open quote
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h00, 1'b1);      // end right after a closing quote
    send_item(CH_CR, 1'b0);
    send_item(8'h00, 1'b1);      // end after a record's CR

    // Random: receiver-heavy idling, then sender-heavy, then none but one long stall
    src_idle_pct  = 29;
    sink_idle_pct <= 85;
    run_random(540);
    src_idle_pct  = 85;
    sink_idle_pct <= 29;
    run_random(540);
    src_idle_pct  = 0;
    sink_idle_pct <= 0;
    stall_req     <= 1'b1;
    run_random(540);
    in_valid <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    while (chk_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d items including %0d end-of-stream marks", n_sent, n_eoi);
    $display("Checked %0d result items closing %0d records", chk_checked, chk_records);
    if (chk_fail == 0) begin
      $display("csv_byte_tokenizer_top verification clean");
    end else begin
      $display("csv_byte_tokenizer_top verification failed");
    end
    $finish;
  end

  // Abort a run that hangs
  initial begin
    #3000000;
    $display("csv_byte_tokenizer_top verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/csvt_pkg.sv
sv/csvt_fsm.sv
sv/csv_byte_tokenizer_top.sv
sv/csvt_checker.sv
tb/csv_byte_tokenizer_checker.sv
tb/csv_byte_tokenizer_top_tb.sv
